>>> design/dq_pkg.sv
// Shared types and constants of the double-ended queue.
// Holds the request codes, the status codes and the controller command bundle.
// No dependencies.
package dq_pkg;

   localparam int FUNC_BITS   = 3;
   localparam int STATUS_BITS = 2;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_PEEK_FRONT = 3'd4,
      FUNC_PEEK_BACK  = 3'd5
   } dq_func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } dq_status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // a request transaction completes this cycle
      logic load;     // move the pending result into the output register
   } dq_cmd_type;

endpackage

>>> design/dq_req_if.sv
// Request channel of the double-ended queue: valid/ready handshake with payload.
// Depends on dq_pkg for the request code width.
interface dq_req_if #(
   parameter int WORD_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic [dq_pkg::FUNC_BITS-1:0]  func;
   logic [WORD_BITS-1:0]          data_in;

   modport source (output valid, output func, output data_in, input ready);
   modport sink   (input valid, input func, input data_in, output ready);
endinterface

>>> design/dq_rsp_if.sv
// Response channel of the double-ended queue: valid/ready handshake with payload.
// Depends on dq_pkg for the status width.
interface dq_rsp_if #(
   parameter int WORD_BITS = 32,
   parameter int OCC_BITS  = 5
);
   logic                            valid;
   logic                            ready;
   logic [WORD_BITS-1:0]            data_out;
   logic [dq_pkg::STATUS_BITS-1:0]  status;
   logic [OCC_BITS-1:0]             occupancy;
   logic                            is_empty;

   modport source (output valid, output data_out, output status, output occupancy,
                   output is_empty, input ready);
   modport sink   (input valid, input data_out, input status, input occupancy,
                   input is_empty, output ready);
endinterface

>>> design/double_ended_queue_top.sv
// Double-ended queue of DEPTH words, each WORD_BITS wide, in a circular buffer.
// Each request transaction on req_chan carries func (push front, push back,
// pop front, pop back, peek front, peek back) and data_in. Exactly one
// response transaction follows on rsp_chan with the popped or peeked word,
// a status (ok, empty on pop or peek, full on push) and the occupancy after
// the request, plus an is_empty flag. Refused requests leave the queue as it was.
// A response becomes valid after its request is accepted, once the result has
// passed the registered read port of the slot RAM and then the output register.
// The next request is not taken while a result loads into the output register:
// req_chan drops ready in that load state.
// If rsp_chan stalls, one further request is still taken and its result parks
// in a pending register; req_chan then drops ready until the waiting response
// is taken.
// Reset (synchronous, active high) empties the queue and clears the handshake
// state. Slot contents are not cleared.
module double_ended_queue_top #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   dq_req_if.sink    req_chan,
   dq_rsp_if.source  rsp_chan
);
   import dq_pkg::*;

   dq_cmd_type cmd;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   dq_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_func      (req_chan.func),
      .req_data_in   (req_chan.data_in),
      .rsp_data_out  (rsp_chan.data_out),
      .rsp_status    (rsp_chan.status),
      .rsp_occupancy (rsp_chan.occupancy),
      .rsp_is_empty  (rsp_chan.is_empty)
   );

`ifndef SYNTHESIS
   // The controller never accepts a transaction in a cycle that loads the output.
   a_accept_load_apart: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.load))
      else $error("request accepted while output register loads");

   // A refused push only happens with the queue full.
   a_full_at_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ST_FULL)) |-> (rsp_chan.occupancy == DEPTH))
      else $error("full status with queue not full");

   // A refused pop or peek returns zero and an empty queue.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ST_EMPTY))
         |-> ((rsp_chan.data_out == '0) && rsp_chan.is_empty))
      else $error("empty status with data or stored words");

   // Occupancy never exceeds the capacity.
   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.occupancy <= DEPTH))
      else $error("occupancy above capacity");
`endif
endmodule

>>> design/dq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read data holds its value until the next enabled read. No dependencies.
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/dq_ctrl.sv
// Controller of the double-ended queue: sequences request and response transactions.
// Depends on dq_pkg for the command bundle.
module dq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dq_pkg::dq_cmd_type cmd
);
   import dq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,
      S_RESP,
      S_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      valid_ff, valid_in;
   logic      accept;
   logic      fire;

   assign accept = req_valid && ready_ff;
   assign fire   = valid_ff && rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            // A new transaction may be taken while the current result waits;
            // its result then parks in the pending registers.
            if (accept && fire) begin
               state_in = S_LOAD;
            end else if (accept) begin
               state_in = S_HOLD;
            end else if (fire) begin
               state_in = S_IDLE;
            end
         end
         S_HOLD: begin
            if (fire) begin
               state_in = S_RESP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      ready_in = (state_in == S_IDLE) || (state_in == S_RESP);
      valid_in = (state_in == S_RESP) || (state_in == S_HOLD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready  = ready_ff;
   assign rsp_valid  = valid_ff;
   assign cmd.accept = accept;
   assign cmd.load   = (state_ff == S_LOAD) || ((state_ff == S_HOLD) && fire);
endmodule

>>> design/dq_datapath.sv
// Datapath of the double-ended queue: front pointer, occupancy count, slot RAM,
// pending result and output registers. Depends on dq_pkg and dq_ram.
module dq_datapath #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dq_pkg::dq_cmd_type               cmd,
   input  logic [dq_pkg::FUNC_BITS-1:0]     req_func,
   input  logic [WORD_BITS-1:0]             req_data_in,
   output logic [WORD_BITS-1:0]             rsp_data_out,
   output logic [dq_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_occupancy,
   output logic                             rsp_is_empty
);
   import dq_pkg::*;

   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int SUM_BITS = IDX_BITS + 1;
   localparam logic [SUM_BITS-1:0] DEPTH_S = SUM_BITS'(DEPTH);
   localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(DEPTH);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(DEPTH - 1);

   logic [IDX_BITS-1:0]   head_ff, head_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   dq_status_type         pend_status_ff, pend_status_in;
   logic                  pend_rd_ff, pend_rd_in;
   logic [CNT_BITS-1:0]   pend_occ_ff;
   logic [WORD_BITS-1:0]  data_out_ff;
   dq_status_type         status_ff;
   logic [CNT_BITS-1:0]   occ_ff;

   logic                  full;
   logic                  empty;
   logic [SUM_BITS-1:0]   tail_sum;
   logic [SUM_BITS-1:0]   back_sum;
   logic [IDX_BITS-1:0]   tail_idx;
   logic [IDX_BITS-1:0]   back_idx;
   logic [IDX_BITS-1:0]   head_dec;
   logic [IDX_BITS-1:0]   head_inc;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [WORD_BITS-1:0]  rd_data;

   assign full  = (count_ff == DEPTH_C);
   assign empty = (count_ff == '0);

   // The sums stay below twice the depth, so one conditional subtract wraps them.
   assign tail_sum = {1'b0, head_ff} + SUM_BITS'(count_ff);
   assign back_sum = tail_sum - SUM_BITS'(1);
   assign tail_idx = (tail_sum >= DEPTH_S) ? IDX_BITS'(tail_sum - DEPTH_S)
                                           : IDX_BITS'(tail_sum);
   assign back_idx = (back_sum >= DEPTH_S) ? IDX_BITS'(back_sum - DEPTH_S)
                                           : IDX_BITS'(back_sum);
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - IDX_BITS'(1);
   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_BITS'(1);

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      pend_status_in = ST_OK;
      pend_rd_in     = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = tail_idx;
      rd_en          = 1'b0;
      rd_addr        = head_ff;
      if (cmd.accept) begin
         case (dq_func_type'(req_func))
            FUNC_PUSH_FRONT: begin
               if (full) begin
                  pend_status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  head_in  = head_dec;
                  count_in = count_ff + CNT_BITS'(1);
               end
            end
            FUNC_PUSH_BACK: begin
               if (full) begin
                  pend_status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_idx;
                  count_in = count_ff + CNT_BITS'(1);
               end
            end
            FUNC_POP_FRONT, FUNC_PEEK_FRONT: begin
               if (empty) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  rd_en      = 1'b1;
                  rd_addr    = head_ff;
                  pend_rd_in = 1'b1;
                  if (dq_func_type'(req_func) == FUNC_POP_FRONT) begin
                     head_in  = head_inc;
                     count_in = count_ff - CNT_BITS'(1);
                  end
               end
            end
            FUNC_POP_BACK, FUNC_PEEK_BACK: begin
               if (empty) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  rd_en      = 1'b1;
                  rd_addr    = back_idx;
                  pend_rd_in = 1'b1;
                  if (dq_func_type'(req_func) == FUNC_POP_BACK) begin
                     count_in = count_ff - CNT_BITS'(1);
                  end
               end
            end
            default: begin
               // Unused codes leave the queue alone and report success.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pend_status_ff <= pend_status_in;
         pend_rd_ff     <= pend_rd_in;
         pend_occ_ff    <= count_in;
      end
      if (cmd.load) begin
         data_out_ff <= pend_rd_ff ? rd_data : '0;
         status_ff   <= pend_status_ff;
         occ_ff      <= pend_occ_ff;
      end
   end

   dq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_data_out  = data_out_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occ_ff;
   assign rsp_is_empty  = (occ_ff == '0);
endmodule
